// ===== hdl/ptm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptm_pkg: shared types and constants of the page table mapper
// Result codes, the result record and the address split of a 32-bit
// virtual address into directory index, table index and page offset.
// ----------------------------------------------------------------------------
package ptm_pkg;

   localparam int unsigned VA_W         = 32;
   localparam int unsigned PAGE_SHIFT   = 12;
   localparam int unsigned PAGE_W       = VA_W - PAGE_SHIFT;
   localparam int unsigned IDX_W        = 10;
   localparam int unsigned REGION_PAGES = 1024;
   localparam int unsigned FLAGS_W      = 8;

   localparam logic [VA_W-1:0] POOL_TOP_RESET = 32'h003f_f000;

   typedef enum logic [1:0] {
      STAT_MAPPED    = 2'd0,
      STAT_ALREADY   = 2'd1,
      STAT_EXHAUSTED = 2'd2
   } status_type;

   typedef struct packed {
      logic       table_allocated;
      status_type status;
   } rsp_type;

endpackage

// ===== hdl/ptm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptm_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module ptm_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/ptm_walker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptm_walker: mapping sequencer
// Reduces the indexes, reads the directory, allocates and clears tables,
// then reads and updates the table entry; walks 1024 pages for a region.
// ----------------------------------------------------------------------------
module ptm_walker
   import ptm_pkg::*;
#(
   parameter int unsigned DIR_ENTRIES   = 1024,
   parameter int unsigned TABLE_ENTRIES = 1024,
   parameter int unsigned POOL_TABLES   = 16,
   localparam int unsigned DIR_AW = $clog2(DIR_ENTRIES),
   localparam int unsigned SLOT_W = (POOL_TABLES > 1) ? $clog2(POOL_TABLES) : 1,
   localparam int unsigned DIR_W  = SLOT_W + 1,
   localparam int unsigned TBL_AW = $clog2(POOL_TABLES * TABLE_ENTRIES)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [VA_W-1:0]   pool_top,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_region,
   input  logic [PAGE_W-1:0] req_page,
   input  logic              req_entry_bit,
   input  logic              req_dir_bit,
   output logic              res_valid,
   input  logic              res_ready,
   output rsp_type           res,
   output logic              dir_we,
   output logic [DIR_AW-1:0] dir_waddr,
   output logic [DIR_W-1:0]  dir_wdata,
   output logic              dir_re,
   output logic [DIR_AW-1:0] dir_raddr,
   input  logic [DIR_W-1:0]  dir_rdata,
   output logic              tbl_we,
   output logic [TBL_AW-1:0] tbl_waddr,
   output logic              tbl_wdata,
   output logic              tbl_re,
   output logic [TBL_AW-1:0] tbl_raddr,
   input  logic              tbl_rdata
);

   localparam int unsigned TIX_W   = $clog2(TABLE_ENTRIES);
   localparam int unsigned USED_W  = $clog2(POOL_TABLES + 1);
   localparam int unsigned CNT_W   = (DIR_AW > TIX_W) ? DIR_AW : TIX_W;
   localparam int unsigned SPLIT   = IDX_W / 2;
   localparam int unsigned PCNT_W  = $clog2(REGION_PAGES);

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_IDX_HI,
      ST_IDX_LO,
      ST_DIR_WAIT,
      ST_TBL_CLR,
      ST_TBL_SET,
      ST_TBL_RD,
      ST_TBL_WAIT,
      ST_DONE
   } state_type;

   // restoring remainder, only the shift positions hi..lo
   function automatic logic [IDX_W-1:0] mod_steps(input logic [IDX_W-1:0] x,
                                                  input logic [2*IDX_W-1:0] d,
                                                  input int hi, input int lo);
      logic [2*IDX_W-1:0] r;
      r = {{IDX_W{1'b0}}, x};
      for (int k = IDX_W - 1; k >= 0; k--) begin
         if (k <= hi && k >= lo && r >= (d << k)) begin
            r = r - (d << k);
         end
      end
      return r[IDX_W-1:0];
   endfunction

   state_type           state_ff, state_in;
   logic [PAGE_W-1:0]   page_ff, page_in;
   logic                region_ff, region_in;
   logic                ent_bit_ff, ent_bit_in;
   logic                dir_bit_ff, dir_bit_in;
   logic [PCNT_W-1:0]   page_cnt_ff, page_cnt_in;
   logic                took_ff, took_in;
   logic                exh_ff, exh_in;
   logic [IDX_W-1:0]    di_part_ff, di_part_in;
   logic [IDX_W-1:0]    ti_part_ff, ti_part_in;
   logic [DIR_AW-1:0]   di_ff, di_in;
   logic [TIX_W-1:0]    ti_ff, ti_in;
   logic [TBL_AW-1:0]   tbl_addr_ff, tbl_addr_in;
   logic [TBL_AW-1:0]   tbl_base_ff, tbl_base_in;
   logic [CNT_W-1:0]    clr_cnt_ff, clr_cnt_in;
   logic [USED_W-1:0]   tables_used_ff, tables_used_in;
   status_type          status_ff, status_in;

   logic [IDX_W-1:0]    di_full;
   logic [IDX_W-1:0]    ti_full;
   logic                dir_present;
   logic [SLOT_W-1:0]   slot_sel;
   logic [TBL_AW-1:0]   slot_base;
   logic [VA_W-1:0]     need_bytes;
   logic                pool_empty;
   logic                page_end;
   status_type          page_stat;

   assign di_full     = mod_steps(di_part_ff, (2*IDX_W)'(DIR_ENTRIES), SPLIT - 1, 0);
   assign ti_full     = mod_steps(ti_part_ff, (2*IDX_W)'(TABLE_ENTRIES), SPLIT - 1, 0);
   assign dir_present = dir_rdata[DIR_W-1];
   assign slot_sel    = dir_present ? dir_rdata[SLOT_W-1:0] : SLOT_W'(tables_used_ff);
   assign slot_base   = TBL_AW'(slot_sel) * TBL_AW'(TABLE_ENTRIES);
   assign need_bytes  = (VA_W'(tables_used_ff) + VA_W'(1)) << PAGE_SHIFT;
   assign pool_empty  = (tables_used_ff >= USED_W'(POOL_TABLES)) || (need_bytes > pool_top);

   assign req_ready = (state_ff == ST_IDLE);
   assign res_valid = (state_ff == ST_DONE);
   assign res       = '{table_allocated: took_ff, status: status_ff};

   always_comb begin
      state_in       = state_ff;
      page_in        = page_ff;
      region_in      = region_ff;
      ent_bit_in     = ent_bit_ff;
      dir_bit_in     = dir_bit_ff;
      page_cnt_in    = page_cnt_ff;
      took_in        = took_ff;
      exh_in         = exh_ff;
      di_part_in     = di_part_ff;
      ti_part_in     = ti_part_ff;
      di_in          = di_ff;
      ti_in          = ti_ff;
      tbl_addr_in    = tbl_addr_ff;
      tbl_base_in    = tbl_base_ff;
      clr_cnt_in     = clr_cnt_ff;
      tables_used_in = tables_used_ff;
      status_in      = status_ff;
      dir_we         = 1'b0;
      dir_waddr      = di_ff;
      dir_wdata      = '0;
      dir_re         = 1'b0;
      dir_raddr      = di_full[DIR_AW-1:0];
      tbl_we         = 1'b0;
      tbl_waddr      = tbl_addr_ff;
      tbl_wdata      = ent_bit_ff;
      tbl_re         = 1'b0;
      tbl_raddr      = tbl_addr_ff;
      page_end       = 1'b0;
      page_stat      = STAT_MAPPED;

      case (state_ff)
         ST_INIT: begin
            // sweep the directory to not-present
            dir_we    = 1'b1;
            dir_waddr = clr_cnt_ff[DIR_AW-1:0];
            if (clr_cnt_ff == CNT_W'(DIR_ENTRIES - 1)) begin
               clr_cnt_in = '0;
               state_in   = ST_IDLE;
            end else begin
               clr_cnt_in = clr_cnt_ff + CNT_W'(1);
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               page_in     = req_page;
               region_in   = req_region;
               ent_bit_in  = req_entry_bit;
               dir_bit_in  = req_dir_bit;
               page_cnt_in = '0;
               took_in     = 1'b0;
               exh_in      = 1'b0;
               state_in    = ST_IDX_HI;
            end
         end
         ST_IDX_HI: begin
            di_part_in = mod_steps(page_ff[PAGE_W-1 -: IDX_W], (2*IDX_W)'(DIR_ENTRIES),
                                   IDX_W - 1, SPLIT);
            ti_part_in = mod_steps(page_ff[IDX_W-1:0], (2*IDX_W)'(TABLE_ENTRIES),
                                   IDX_W - 1, SPLIT);
            state_in   = ST_IDX_LO;
         end
         ST_IDX_LO: begin
            dir_re   = 1'b1;
            di_in    = di_full[DIR_AW-1:0];
            ti_in    = ti_full[TIX_W-1:0];
            state_in = ST_DIR_WAIT;
         end
         ST_DIR_WAIT: begin
            tbl_addr_in = slot_base + TBL_AW'(ti_ff);
            if (region_ff && page_cnt_ff == '0 && dir_present) begin
               status_in = STAT_ALREADY;
               state_in  = ST_DONE;
            end else if (dir_present) begin
               state_in = ST_TBL_RD;
            end else if (pool_empty) begin
               page_end  = 1'b1;
               page_stat = STAT_EXHAUSTED;
            end else begin
               // take the next table and point the directory at it
               dir_we         = 1'b1;
               dir_wdata      = {dir_bit_ff, slot_sel};
               tables_used_in = tables_used_ff + USED_W'(1);
               took_in        = 1'b1;
               tbl_base_in    = slot_base;
               clr_cnt_in     = '0;
               state_in       = ST_TBL_CLR;
            end
         end
         ST_TBL_CLR: begin
            tbl_we    = 1'b1;
            tbl_waddr = tbl_base_ff + TBL_AW'(clr_cnt_ff[TIX_W-1:0]);
            tbl_wdata = 1'b0;
            if (clr_cnt_ff == CNT_W'(TABLE_ENTRIES - 1)) begin
               clr_cnt_in = '0;
               state_in   = ST_TBL_SET;
            end else begin
               clr_cnt_in = clr_cnt_ff + CNT_W'(1);
            end
         end
         ST_TBL_SET: begin
            tbl_we   = 1'b1;
            page_end = 1'b1;
         end
         ST_TBL_RD: begin
            tbl_re   = 1'b1;
            state_in = ST_TBL_WAIT;
         end
         ST_TBL_WAIT: begin
            page_end = 1'b1;
            if (tbl_rdata) begin
               page_stat = STAT_ALREADY;
            end else begin
               tbl_we = 1'b1;
            end
         end
         ST_DONE: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (page_end) begin
         if (!region_ff) begin
            status_in = page_stat;
            state_in  = ST_DONE;
         end else begin
            if (page_stat == STAT_EXHAUSTED) begin
               exh_in = 1'b1;
            end
            if (page_cnt_ff == PCNT_W'(REGION_PAGES - 1)) begin
               status_in = (exh_in) ? STAT_EXHAUSTED : STAT_MAPPED;
               state_in  = ST_DONE;
            end else begin
               page_cnt_in = page_cnt_ff + PCNT_W'(1);
               page_in     = page_ff + PAGE_W'(1);
               state_in    = ST_IDX_HI;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_INIT;
         clr_cnt_ff     <= '0;
         tables_used_ff <= '0;
         page_cnt_ff    <= '0;
         took_ff        <= 1'b0;
         exh_ff         <= 1'b0;
         region_ff      <= 1'b0;
         status_ff      <= STAT_MAPPED;
      end else begin
         state_ff       <= state_in;
         clr_cnt_ff     <= clr_cnt_in;
         tables_used_ff <= tables_used_in;
         page_cnt_ff    <= page_cnt_in;
         took_ff        <= took_in;
         exh_ff         <= exh_in;
         region_ff      <= region_in;
         status_ff      <= status_in;
      end
      page_ff     <= page_in;
      ent_bit_ff  <= ent_bit_in;
      dir_bit_ff  <= dir_bit_in;
      di_part_ff  <= di_part_in;
      ti_part_ff  <= ti_part_in;
      di_ff       <= di_in;
      ti_ff       <= ti_in;
      tbl_addr_ff <= tbl_addr_in;
      tbl_base_ff <= tbl_base_in;
   end

`ifndef SYNTHESIS
   a_used_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && tables_used_ff != $past(tables_used_ff)) |->
      ($past(state_ff) == ST_DIR_WAIT &&
       tables_used_ff == $past(tables_used_ff) + USED_W'(1)))
      else $error("table count moved outside an allocation");

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      tables_used_ff <= USED_W'(POOL_TABLES))
      else $error("table count beyond pool size");

   a_tbl_port: assert property (@(posedge clock) disable iff (reset)
      !(tbl_we && tbl_re))
      else $error("table read and write in the same cycle");

   a_already_no_alloc: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res.status == STAT_ALREADY) |-> !res.table_allocated)
      else $error("already-mapped result with a new table");
`endif

endmodule

// ===== hdl/page_table_mapper_top.sv =====
// A 4 KiB request whose directory entry is present reads and, if clear, sets its table entry,
//   then returns its beat; no new request is taken until that beat is in the result register.
// Taking a table adds a sweep that clears its TABLE_ENTRIES entries. A 4 KiB request
//   refused for an empty pool, or a 4 MiB request whose first directory entry is
//   present, returns its beat after the directory read; a 4 MiB request walks 1024 pages.
// Reset is synchronous; then the directory is swept, req_tready low.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_table_mapper_top: two-level page directory and table pool mapper
// Holds the pool_top register, the directory RAM, the table RAM and the
// result register; the walker sequences each mapping request.
// ----------------------------------------------------------------------------
module page_table_mapper_top
   import ptm_pkg::*;
#(
   parameter int unsigned DIR_ENTRIES   = 1024,
   parameter int unsigned TABLE_ENTRIES = 1024,
   parameter int unsigned POOL_TABLES   = 16
) (
   input  logic        clock,
   input  logic        reset,
   // configuration write: pool_top
   input  logic        csr_tvalid,
   output logic        csr_tready,
   input  logic [31:0] csr_tdata,     // pool_top
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,     // virt_addr[31:0], phys_addr[63:32], flags[71:64]
   input  logic        req_tuser,     // req_type
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata      // status[1:0], table_allocated[2], zero[7:3]
);

   localparam int unsigned DIR_AW = $clog2(DIR_ENTRIES);
   localparam int unsigned SLOT_W = (POOL_TABLES > 1) ? $clog2(POOL_TABLES) : 1;
   localparam int unsigned DIR_W  = SLOT_W + 1;
   localparam int unsigned TBL_AW = $clog2(POOL_TABLES * TABLE_ENTRIES);
   localparam int unsigned PA_LSB = VA_W;
   localparam int unsigned FL_LSB = 2 * VA_W;

   logic [VA_W-1:0]   pool_top_ff, pool_top_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              res_valid;
   logic              res_ready;
   rsp_type           res;
   logic              entry_bit;
   logic              dir_bit;

   logic              dir_we, dir_re;
   logic [DIR_AW-1:0] dir_waddr, dir_raddr;
   logic [DIR_W-1:0]  dir_wdata, dir_rdata;
   logic              tbl_we, tbl_re;
   logic [TBL_AW-1:0] tbl_waddr, tbl_raddr;
   logic              tbl_wdata, tbl_rdata;

   // Only the present bits of the entries steer the mapping: a page entry is
   // present when phys_addr or flags carries bit 0, a directory entry when
   // flags does.
   assign entry_bit = req_tdata[PA_LSB] | req_tdata[FL_LSB];
   assign dir_bit   = req_tdata[FL_LSB];

   // Configuration is always taken; write it only while no request is in flight.
   assign csr_tready = 1'b1;
   assign pool_top_in = (csr_tvalid) ? csr_tdata : pool_top_ff;

   // Output register: hold the beat until taken, accept a new one when the
   // slot is empty or drains in the same cycle.
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_top_ff  <= POOL_TOP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         pool_top_ff  <= pool_top_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_ff};

   ptm_walker #(
      .DIR_ENTRIES   (DIR_ENTRIES),
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .POOL_TABLES   (POOL_TABLES)
   ) u_walker (
      .clock         (clock),
      .reset         (reset),
      .pool_top      (pool_top_ff),
      .req_valid     (req_tvalid),
      .req_ready     (req_tready),
      .req_region    (req_tuser),
      .req_page      (req_tdata[VA_W-1:PAGE_SHIFT]),
      .req_entry_bit (entry_bit),
      .req_dir_bit   (dir_bit),
      .res_valid     (res_valid),
      .res_ready     (res_ready),
      .res           (res),
      .dir_we        (dir_we),
      .dir_waddr     (dir_waddr),
      .dir_wdata     (dir_wdata),
      .dir_re        (dir_re),
      .dir_raddr     (dir_raddr),
      .dir_rdata     (dir_rdata),
      .tbl_we        (tbl_we),
      .tbl_waddr     (tbl_waddr),
      .tbl_wdata     (tbl_wdata),
      .tbl_re        (tbl_re),
      .tbl_raddr     (tbl_raddr),
      .tbl_rdata     (tbl_rdata)
   );

   // Directory: present bit over pool table number.
   ptm_ram #(
      .WIDTH (DIR_W),
      .DEPTH (DIR_ENTRIES)
   ) u_dir_ram (
      .clock   (clock),
      .wr_en   (dir_we),
      .wr_addr (dir_waddr),
      .wr_data (dir_wdata),
      .rd_en   (dir_re),
      .rd_addr (dir_raddr),
      .rd_data (dir_rdata)
   );

   // Table pool: one present bit per page entry, tables back to back.
   ptm_ram #(
      .WIDTH (1),
      .DEPTH (POOL_TABLES * TABLE_ENTRIES)
   ) u_tbl_ram (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (tbl_waddr),
      .wr_data (tbl_wdata),
      .rd_en   (tbl_re),
      .rd_addr (tbl_raddr),
      .rd_data (tbl_rdata)
   );

endmodule
